/* hdl/dptw_pkg.sv */
// ============================================================================
// dptw_pkg: shared types and constants for depth pixel back-projection
// Field widths, fixed-point formats, register map and reset values.
// ============================================================================
package dptw_pkg;

   // Pixel coordinate widths.
   localparam int COLUMN_BITS = 10;
   localparam int ROW_BITS    = 10;

   localparam int DEPTH_BITS  = 16;
   localparam int COLOR_BITS  = 8;
   localparam int RECIP_BITS  = 24;
   localparam int PP_BITS     = 16;
   localparam int SUBPIX_BITS = 4;
   localparam int COEF_BITS   = 18;
   localparam int TRANS_BITS  = 20;
   localparam int COORD_BITS  = 25;
   localparam int CAM_BITS    = 41;

   // Column or row moved to Q.4 and reduced by the principal point.
   localparam int IDX_BITS = ((COLUMN_BITS > ROW_BITS) ? COLUMN_BITS : ROW_BITS) + SUBPIX_BITS;
   localparam int DU_BITS  = ((IDX_BITS > PP_BITS) ? IDX_BITS : PP_BITS) + 1;

   localparam int FOCAL_SHIFT = 12;
   localparam int DEPTH_SHIFT = 8;
   localparam int CAM_SHIFT   = 16;
   localparam int ROT_SHIFT   = 16;

   localparam int XP_BITS  = DU_BITS + RECIP_BITS + 1;
   localparam int XN_BITS  = XP_BITS - FOCAL_SHIFT;
   localparam int ZP_BITS  = DEPTH_BITS + RECIP_BITS;
   localparam int Z_BITS   = ZP_BITS - DEPTH_SHIFT;
   localparam int CP_BITS  = XN_BITS + Z_BITS + 1;
   localparam int CS_BITS  = CP_BITS - CAM_SHIFT;
   localparam int RP_BITS  = COEF_BITS + CAM_BITS;
   localparam int ACC_BITS = RP_BITS + 2;
   localparam int WS_BITS  = ACC_BITS - ROT_SHIFT + 1;

   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_BITS = 2;

   localparam int IN_FIELD_BITS  = COLUMN_BITS + ROW_BITS + DEPTH_BITS + 3 * COLOR_BITS;
   localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
   localparam int OUT_FIELD_BITS = 3 * COORD_BITS + 3 * COLOR_BITS;
   localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
   localparam int OUT_PAD_BITS   = OUT_DATA_BITS - OUT_FIELD_BITS;

   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_ADDR_BITS  = 6;
   localparam int CSR_INDEX_LSB  = 3;
   localparam int CSR_INDEX_BITS = CSR_ADDR_BITS - CSR_INDEX_LSB;

   localparam logic [RECIP_BITS-1:0]     INV_FOCAL_X_RESET     = 24'd32388;
   localparam logic [RECIP_BITS-1:0]     INV_FOCAL_Y_RESET     = 24'd32326;
   localparam logic [2*PP_BITS-1:0]      PRINCIPAL_POINT_RESET = 32'd265819224;
   localparam logic [RECIP_BITS-1:0]     INV_DEPTH_SCALE_RESET = 24'd16777;
   localparam logic [3*COEF_BITS-1:0]    ROTATION_ROW0_RESET   = 54'd65536;
   localparam logic [3*COEF_BITS-1:0]    ROTATION_ROW1_RESET   = 54'd17179869184;
   localparam logic [3*COEF_BITS-1:0]    ROTATION_ROW2_RESET   = 54'd4503599627370496;
   localparam logic [3*TRANS_BITS-1:0]   TRANSLATION_RESET     = 60'd0;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_INV_FOCAL_X     = 3'd0,
      REG_INV_FOCAL_Y     = 3'd1,
      REG_PRINCIPAL_POINT = 3'd2,
      REG_INV_DEPTH_SCALE = 3'd3,
      REG_ROTATION_ROW0   = 3'd4,
      REG_ROTATION_ROW1   = 3'd5,
      REG_ROTATION_ROW2   = 3'd6,
      REG_TRANSLATION     = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [COLOR_BITS-1:0] red;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] blue;
   } color_type;

   typedef struct packed {
      logic [RECIP_BITS-1:0]                inv_focal_x;
      logic [RECIP_BITS-1:0]                inv_focal_y;
      logic [PP_BITS-1:0]                   cx;
      logic [PP_BITS-1:0]                   cy;
      logic [RECIP_BITS-1:0]                inv_depth_scale;
      logic [2:0][2:0][COEF_BITS-1:0]       rotation;
      logic [2:0][TRANS_BITS-1:0]           translation;
   } cfg_type;

   typedef struct packed {
      logic signed [DU_BITS-1:0] du;
      logic signed [DU_BITS-1:0] dv;
      logic [DEPTH_BITS-1:0]     depth;
      color_type                 color;
   } item_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] world_x;
      logic [COORD_BITS-1:0] world_y;
      logic [COORD_BITS-1:0] world_z;
      color_type             color;
   } result_type;

endpackage

/* hdl/dptw_csr.sv */
// ============================================================================
// dptw_csr: configuration register file
// Holds the camera intrinsics, depth scale, rotation and translation.
// ============================================================================
module dptw_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [dptw_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [dptw_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [dptw_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                   csr_pready,
   output dptw_pkg::cfg_type                      cfg
);

   logic [dptw_pkg::RECIP_BITS-1:0]     inv_focal_x_ff, inv_focal_x_in;
   logic [dptw_pkg::RECIP_BITS-1:0]     inv_focal_y_ff, inv_focal_y_in;
   logic [2*dptw_pkg::PP_BITS-1:0]      principal_point_ff, principal_point_in;
   logic [dptw_pkg::RECIP_BITS-1:0]     inv_depth_scale_ff, inv_depth_scale_in;
   logic [3*dptw_pkg::COEF_BITS-1:0]    rotation_row0_ff, rotation_row0_in;
   logic [3*dptw_pkg::COEF_BITS-1:0]    rotation_row1_ff, rotation_row1_in;
   logic [3*dptw_pkg::COEF_BITS-1:0]    rotation_row2_ff, rotation_row2_in;
   logic [3*dptw_pkg::TRANS_BITS-1:0]   translation_ff, translation_in;

   logic                                write_en;
   dptw_pkg::reg_index_type             index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign index      = dptw_pkg::reg_index_type'(
                          csr_paddr[dptw_pkg::CSR_ADDR_BITS-1:dptw_pkg::CSR_INDEX_LSB]);

   always_comb begin
      inv_focal_x_in     = inv_focal_x_ff;
      inv_focal_y_in     = inv_focal_y_ff;
      principal_point_in = principal_point_ff;
      inv_depth_scale_in = inv_depth_scale_ff;
      rotation_row0_in   = rotation_row0_ff;
      rotation_row1_in   = rotation_row1_ff;
      rotation_row2_in   = rotation_row2_ff;
      translation_in     = translation_ff;
      if (write_en) begin
         case (index)
            dptw_pkg::REG_INV_FOCAL_X: begin
               inv_focal_x_in = csr_pwdata[dptw_pkg::RECIP_BITS-1:0];
            end
            dptw_pkg::REG_INV_FOCAL_Y: begin
               inv_focal_y_in = csr_pwdata[dptw_pkg::RECIP_BITS-1:0];
            end
            dptw_pkg::REG_PRINCIPAL_POINT: begin
               principal_point_in = csr_pwdata[2*dptw_pkg::PP_BITS-1:0];
            end
            dptw_pkg::REG_INV_DEPTH_SCALE: begin
               inv_depth_scale_in = csr_pwdata[dptw_pkg::RECIP_BITS-1:0];
            end
            dptw_pkg::REG_ROTATION_ROW0: begin
               rotation_row0_in = csr_pwdata[3*dptw_pkg::COEF_BITS-1:0];
            end
            dptw_pkg::REG_ROTATION_ROW1: begin
               rotation_row1_in = csr_pwdata[3*dptw_pkg::COEF_BITS-1:0];
            end
            dptw_pkg::REG_ROTATION_ROW2: begin
               rotation_row2_in = csr_pwdata[3*dptw_pkg::COEF_BITS-1:0];
            end
            dptw_pkg::REG_TRANSLATION: begin
               translation_in = csr_pwdata[3*dptw_pkg::TRANS_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_focal_x_ff     <= dptw_pkg::INV_FOCAL_X_RESET;
         inv_focal_y_ff     <= dptw_pkg::INV_FOCAL_Y_RESET;
         principal_point_ff <= dptw_pkg::PRINCIPAL_POINT_RESET;
         inv_depth_scale_ff <= dptw_pkg::INV_DEPTH_SCALE_RESET;
         rotation_row0_ff   <= dptw_pkg::ROTATION_ROW0_RESET;
         rotation_row1_ff   <= dptw_pkg::ROTATION_ROW1_RESET;
         rotation_row2_ff   <= dptw_pkg::ROTATION_ROW2_RESET;
         translation_ff     <= dptw_pkg::TRANSLATION_RESET;
      end else begin
         inv_focal_x_ff     <= inv_focal_x_in;
         inv_focal_y_ff     <= inv_focal_y_in;
         principal_point_ff <= principal_point_in;
         inv_depth_scale_ff <= inv_depth_scale_in;
         rotation_row0_ff   <= rotation_row0_in;
         rotation_row1_ff   <= rotation_row1_in;
         rotation_row2_ff   <= rotation_row2_in;
         translation_ff     <= translation_in;
      end
   end

   always_comb begin
      case (index)
         dptw_pkg::REG_INV_FOCAL_X: begin
            csr_prdata = dptw_pkg::CSR_DATA_BITS'(inv_focal_x_ff);
         end
         dptw_pkg::REG_INV_FOCAL_Y: begin
            csr_prdata = dptw_pkg::CSR_DATA_BITS'(inv_focal_y_ff);
         end
         dptw_pkg::REG_PRINCIPAL_POINT: begin
            csr_prdata = dptw_pkg::CSR_DATA_BITS'(principal_point_ff);
         end
         dptw_pkg::REG_INV_DEPTH_SCALE: begin
            csr_prdata = dptw_pkg::CSR_DATA_BITS'(inv_depth_scale_ff);
         end
         dptw_pkg::REG_ROTATION_ROW0: begin
            csr_prdata = dptw_pkg::CSR_DATA_BITS'(rotation_row0_ff);
         end
         dptw_pkg::REG_ROTATION_ROW1: begin
            csr_prdata = dptw_pkg::CSR_DATA_BITS'(rotation_row1_ff);
         end
         dptw_pkg::REG_ROTATION_ROW2: begin
            csr_prdata = dptw_pkg::CSR_DATA_BITS'(rotation_row2_ff);
         end
         dptw_pkg::REG_TRANSLATION: begin
            csr_prdata = dptw_pkg::CSR_DATA_BITS'(translation_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_comb begin
      cfg.inv_focal_x     = inv_focal_x_ff;
      cfg.inv_focal_y     = inv_focal_y_ff;
      cfg.cx              = principal_point_ff[dptw_pkg::PP_BITS-1:0];
      cfg.cy              = principal_point_ff[2*dptw_pkg::PP_BITS-1:dptw_pkg::PP_BITS];
      cfg.inv_depth_scale = inv_depth_scale_ff;
      cfg.rotation[0]     = rotation_row0_ff;
      cfg.rotation[1]     = rotation_row1_ff;
      cfg.rotation[2]     = rotation_row2_ff;
      cfg.translation     = translation_ff;
   end

endmodule

/* hdl/dptw_front.sv */
// ============================================================================
// dptw_front: input stage
// Accepts pixel beats, drops pixels without depth and centers the pixel
// coordinates on the principal point before handing the item to the queue.
// ============================================================================
module dptw_front (
   input  logic                                clock,
   input  logic                                reset,
   input  dptw_pkg::cfg_type                   cfg,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dptw_pkg::IN_DATA_BITS-1:0]   req_tdata,
   output logic                                push_valid,
   output dptw_pkg::item_type                  push_item,
   input  logic                                queue_full
);

   localparam int ROW_LSB   = dptw_pkg::COLUMN_BITS;
   localparam int DEPTH_LSB = ROW_LSB + dptw_pkg::ROW_BITS;
   localparam int COLOR_LSB = DEPTH_LSB + dptw_pkg::DEPTH_BITS;

   logic                                 front_valid_ff, front_valid_in;
   dptw_pkg::item_type                   item_ff, item_in;

   logic [dptw_pkg::COLUMN_BITS-1:0]     column;
   logic [dptw_pkg::ROW_BITS-1:0]        row_index;
   logic [dptw_pkg::DEPTH_BITS-1:0]      raw_depth;
   logic signed [dptw_pkg::DU_BITS-1:0]  u_ext, v_ext, cx_ext, cy_ext;

   assign column    = req_tdata[dptw_pkg::COLUMN_BITS-1:0];
   assign row_index = req_tdata[DEPTH_LSB-1:ROW_LSB];
   assign raw_depth = req_tdata[COLOR_LSB-1:DEPTH_LSB];

   // Pixel indexes move to Q.4 so they line up with the principal point.
   assign u_ext  = dptw_pkg::DU_BITS'({column, {dptw_pkg::SUBPIX_BITS{1'b0}}});
   assign v_ext  = dptw_pkg::DU_BITS'({row_index, {dptw_pkg::SUBPIX_BITS{1'b0}}});
   assign cx_ext = dptw_pkg::DU_BITS'(cfg.cx);
   assign cy_ext = dptw_pkg::DU_BITS'(cfg.cy);

   // The held item leaves whenever the queue has room, so a new beat can
   // be taken in the same cycle.
   assign req_tready = !front_valid_ff || !queue_full;
   assign push_valid = front_valid_ff;
   assign push_item  = item_ff;

   always_comb begin
      front_valid_in = front_valid_ff;
      item_in        = item_ff;
      if (req_tready) begin
         front_valid_in = req_tvalid && (raw_depth != '0);
         item_in.du     = u_ext - cx_ext;
         item_in.dv     = v_ext - cy_ext;
         item_in.depth  = raw_depth;
         item_in.color  = dptw_pkg::color_type'(
                             req_tdata[COLOR_LSB+3*dptw_pkg::COLOR_BITS-1:COLOR_LSB]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

/* hdl/dptw_fifo.sv */
// ============================================================================
// dptw_fifo: item queue
// Short queue between the input stage and the arithmetic pipeline.
// ============================================================================
module dptw_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  dptw_pkg::item_type   push_item,
   output logic                 full,
   output logic                 pop_valid,
   output dptw_pkg::item_type   pop_item,
   input  logic                 pop_ready
);

   dptw_pkg::item_type                      entry_ff [dptw_pkg::FIFO_DEPTH];
   logic [dptw_pkg::FIFO_PTR_BITS-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [dptw_pkg::FIFO_PTR_BITS-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [dptw_pkg::FIFO_PTR_BITS:0]        count_ff, count_in;
   logic                                    push, pop;

   assign full      = (count_ff == (dptw_pkg::FIFO_PTR_BITS+1)'(dptw_pkg::FIFO_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign push      = push_valid && !full;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* hdl/dptw_back.sv */
// ============================================================================
// dptw_back: projection pipeline
// Six stages: scale products, camera products, camera clamp, rotation
// products, rotation sums, and translation with saturation into the
// output register.
// ============================================================================
module dptw_back (
   input  logic                   clock,
   input  logic                   reset,
   input  dptw_pkg::cfg_type      cfg,
   input  logic                   pop_valid,
   input  dptw_pkg::item_type     pop_item,
   output logic                   pop_ready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output dptw_pkg::result_type   result
);

   localparam int CAM_BITS   = dptw_pkg::CAM_BITS;
   localparam int CS_BITS    = dptw_pkg::CS_BITS;
   localparam int COORD_BITS = dptw_pkg::COORD_BITS;
   localparam int WS_BITS    = dptw_pkg::WS_BITS;

   logic                                   en;
   logic [5:0]                             valid_ff, valid_in;

   // Stage 1: depth scale and focal products.
   logic [dptw_pkg::ZP_BITS-1:0]           zp1_ff, zp1_in;
   logic signed [dptw_pkg::XP_BITS-1:0]    xp1_ff, xp1_in, yp1_ff, yp1_in;
   // Stage 2: normalized coordinate times depth.
   logic [dptw_pkg::Z_BITS-1:0]            z2_ff, z2_in;
   logic signed [dptw_pkg::CP_BITS-1:0]    xcp2_ff, xcp2_in, ycp2_ff, ycp2_in;
   // Stage 3: camera point after clamping.
   logic [dptw_pkg::Z_BITS-1:0]            z3_ff, z3_in;
   logic signed [CAM_BITS-1:0]             xc3_ff, xc3_in, yc3_ff, yc3_in;
   // Stage 4 and 5: rotation products and their row sums.
   logic signed [dptw_pkg::RP_BITS-1:0]    rp4_ff [3][3];
   logic signed [dptw_pkg::RP_BITS-1:0]    rp4_in [3][3];
   logic signed [dptw_pkg::ACC_BITS-1:0]   acc5_ff [3];
   logic signed [dptw_pkg::ACC_BITS-1:0]   acc5_in [3];
   dptw_pkg::color_type                    color_ff [5];
   dptw_pkg::color_type                    color_in [5];
   dptw_pkg::result_type                   result_ff, result_in;

   logic signed [dptw_pkg::XN_BITS-1:0]    xn, yn;
   logic signed [dptw_pkg::Z_BITS:0]       z_s;
   logic signed [CS_BITS-1:0]              xs, ys;
   logic signed [CAM_BITS-1:0]             cam [3];
   logic signed [dptw_pkg::ACC_BITS-dptw_pkg::ROT_SHIFT-1:0] ws [3];
   logic signed [WS_BITS-1:0]              wt [3];
   logic [COORD_BITS-1:0]                  world [3];

   // The whole pipeline moves together unless the output beat is stuck.
   assign en         = !valid_ff[5] || rsp_tready;
   assign pop_ready  = en;
   assign rsp_tvalid = valid_ff[5];
   assign result     = result_ff;

   always_comb begin
      valid_in = en ? {valid_ff[4:0], pop_valid} : valid_ff;
   end

   // Stage 1.
   always_comb begin
      zp1_in = pop_item.depth * cfg.inv_depth_scale;
      xp1_in = pop_item.du * $signed({1'b0, cfg.inv_focal_x});
      yp1_in = pop_item.dv * $signed({1'b0, cfg.inv_focal_y});
   end

   // Stage 2.
   always_comb begin
      z2_in   = zp1_ff[dptw_pkg::ZP_BITS-1:dptw_pkg::DEPTH_SHIFT];
      xn      = xp1_ff[dptw_pkg::XP_BITS-1:dptw_pkg::FOCAL_SHIFT];
      yn      = yp1_ff[dptw_pkg::XP_BITS-1:dptw_pkg::FOCAL_SHIFT];
      z_s     = $signed({1'b0, z2_in});
      xcp2_in = xn * z_s;
      ycp2_in = yn * z_s;
   end

   // Stage 3: drop the fraction, then saturate to the camera range.
   always_comb begin
      xs    = xcp2_ff[dptw_pkg::CP_BITS-1:dptw_pkg::CAM_SHIFT];
      ys    = ycp2_ff[dptw_pkg::CP_BITS-1:dptw_pkg::CAM_SHIFT];
      z3_in = z2_ff;
      if ((&xs[CS_BITS-1:CAM_BITS-1]) || !(|xs[CS_BITS-1:CAM_BITS-1])) begin
         xc3_in = xs[CAM_BITS-1:0];
      end else begin
         xc3_in = xs[CS_BITS-1] ? {1'b1, {(CAM_BITS-1){1'b0}}} : {1'b0, {(CAM_BITS-1){1'b1}}};
      end
      if ((&ys[CS_BITS-1:CAM_BITS-1]) || !(|ys[CS_BITS-1:CAM_BITS-1])) begin
         yc3_in = ys[CAM_BITS-1:0];
      end else begin
         yc3_in = ys[CS_BITS-1] ? {1'b1, {(CAM_BITS-1){1'b0}}} : {1'b0, {(CAM_BITS-1){1'b1}}};
      end
   end

   // Stage 4: one product per matrix entry.
   always_comb begin
      cam[0] = xc3_ff;
      cam[1] = yc3_ff;
      cam[2] = $signed({{(CAM_BITS-dptw_pkg::Z_BITS){1'b0}}, z3_ff});
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            rp4_in[i][j] = $signed(cfg.rotation[i][j]) * cam[j];
         end
      end
   end

   // Stage 5 and the output stage.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc5_in[i] = rp4_ff[i][0] + rp4_ff[i][1] + rp4_ff[i][2];
         ws[i]      = acc5_ff[i][dptw_pkg::ACC_BITS-1:dptw_pkg::ROT_SHIFT];
         wt[i]      = ws[i] + $signed(cfg.translation[i]);
         if ((&wt[i][WS_BITS-1:COORD_BITS-1]) || !(|wt[i][WS_BITS-1:COORD_BITS-1])) begin
            world[i] = wt[i][COORD_BITS-1:0];
         end else if (wt[i][WS_BITS-1]) begin
            world[i] = {1'b1, {(COORD_BITS-1){1'b0}}};
         end else begin
            world[i] = {1'b0, {(COORD_BITS-1){1'b1}}};
         end
      end
      color_in[0]       = pop_item.color;
      for (int k = 1; k < 5; k++) begin
         color_in[k] = color_ff[k-1];
      end
      result_in.world_x = world[0];
      result_in.world_y = world[1];
      result_in.world_z = world[2];
      result_in.color   = color_ff[4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zp1_ff    <= zp1_in;
         xp1_ff    <= xp1_in;
         yp1_ff    <= yp1_in;
         z2_ff     <= z2_in;
         xcp2_ff   <= xcp2_in;
         ycp2_ff   <= ycp2_in;
         z3_ff     <= z3_in;
         xc3_ff    <= xc3_in;
         yc3_ff    <= yc3_in;
         rp4_ff    <= rp4_in;
         acc5_ff   <= acc5_in;
         color_ff  <= color_in;
         result_ff <= result_in;
      end
   end

endmodule

/* hdl/depth_pixel_to_world_point.sv */
// ============================================================================
// depth_pixel_to_world_point: depth pixel to world point back-projection
// Lifts each depth pixel into the camera frame, rotates and translates it,
// and emits a saturated Q8.16 world point with the pixel color.
// ============================================================================
//
//   Port group   Direction   Beat contents
//   req_*        in          column, row_index, raw_depth, blue, green, red
//   rsp_*        out         world_x, world_y, world_z, out_blue, out_green, out_red
//   csr_*        in/out      APB-style register access, 64-bit data
//
// One pixel per clock is taken and one point per clock is given while rsp_tready
// stays high. A pixel passes through the input stage, the four-entry queue and
// the arithmetic pipeline in turn. Pixels with zero depth are dropped in the input
// stage and give no beat. A stalled output holds the whole pipeline; the queue
// then fills and req_tready falls. Reset clears all control state and loads
// register defaults.
//
module depth_pixel_to_world_point (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // column, row_index, raw_depth, blue, green, red, zero padding
   input  logic [dptw_pkg::IN_DATA_BITS-1:0]    req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // world_x, world_y, world_z, out_blue, out_green, out_red, zero padding
   output logic [dptw_pkg::OUT_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [dptw_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [dptw_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [dptw_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   dptw_pkg::cfg_type      cfg;
   logic                   push_valid, queue_full, pop_valid, pop_ready;
   dptw_pkg::item_type     push_item, pop_item;
   dptw_pkg::result_type   result;

   dptw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dptw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_item  (push_item),
      .queue_full (queue_full)
   );

   dptw_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   dptw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .result     (result)
   );

   assign rsp_tdata = {{dptw_pkg::OUT_PAD_BITS{1'b0}}, result.color,
                       result.world_z, result.world_y, result.world_x};

endmodule

/* tb/testbench.sv */
// ============================================================================
// testbench: self-checking bench for depth pixel back-projection
// Streams depth pixels through the block under several camera settings and
// checks every world point beat against a fixed-point predictor.
// ============================================================================
module testbench;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int LONG_HOLD      = 80;

   localparam longint CAM_HI = 64'sd1099511627775;
   localparam longint CAM_LO = -64'sd1099511627776;
   localparam longint OUT_HI = 64'sd16777215;
   localparam longint OUT_LO = -64'sd16777216;

   typedef struct packed {
      logic [dptw_pkg::COLUMN_BITS-1:0] column;
      logic [dptw_pkg::ROW_BITS-1:0]    row_index;
      logic [dptw_pkg::DEPTH_BITS-1:0]  depth;
      logic [dptw_pkg::COLOR_BITS-1:0]  blue;
      logic [dptw_pkg::COLOR_BITS-1:0]  green;
      logic [dptw_pkg::COLOR_BITS-1:0]  red;
   } pixel_type;

   typedef struct packed {
      logic [dptw_pkg::COORD_BITS-1:0] x;
      logic [dptw_pkg::COORD_BITS-1:0] y;
      logic [dptw_pkg::COORD_BITS-1:0] z;
      logic [dptw_pkg::COLOR_BITS-1:0] blue;
      logic [dptw_pkg::COLOR_BITS-1:0] green;
      logic [dptw_pkg::COLOR_BITS-1:0] red;
   } world_point_type;

   typedef logic [dptw_pkg::CSR_DATA_BITS-1:0] reg_image_type [8];

   // Holds its own copy of the camera registers and the points still owed.
   class point_scoreboard_type;
      logic [dptw_pkg::RECIP_BITS-1:0]     inv_fx, inv_fy, inv_scale;
      logic [dptw_pkg::PP_BITS-1:0]        cx, cy;
      logic [3*dptw_pkg::COEF_BITS-1:0]    rot_row [3];
      logic [3*dptw_pkg::TRANS_BITS-1:0]   shift;
      world_point_type                     expected_points [$];
      int                                  errors;

      function new();
         inv_fx     = dptw_pkg::INV_FOCAL_X_RESET;
         inv_fy     = dptw_pkg::INV_FOCAL_Y_RESET;
         cx         = dptw_pkg::PRINCIPAL_POINT_RESET[dptw_pkg::PP_BITS-1:0];
         cy         = dptw_pkg::PRINCIPAL_POINT_RESET[2*dptw_pkg::PP_BITS-1:dptw_pkg::PP_BITS];
         inv_scale  = dptw_pkg::INV_DEPTH_SCALE_RESET;
         rot_row[0] = dptw_pkg::ROTATION_ROW0_RESET;
         rot_row[1] = dptw_pkg::ROTATION_ROW1_RESET;
         rot_row[2] = dptw_pkg::ROTATION_ROW2_RESET;
         shift      = dptw_pkg::TRANSLATION_RESET;
         errors     = 0;
      endfunction

      function void set_reg(dptw_pkg::reg_index_type idx,
                            logic [dptw_pkg::CSR_DATA_BITS-1:0] value);
         case (idx)
            dptw_pkg::REG_INV_FOCAL_X:     inv_fx = value[dptw_pkg::RECIP_BITS-1:0];
            dptw_pkg::REG_INV_FOCAL_Y:     inv_fy = value[dptw_pkg::RECIP_BITS-1:0];
            dptw_pkg::REG_PRINCIPAL_POINT: begin
               cx = value[dptw_pkg::PP_BITS-1:0];
               cy = value[2*dptw_pkg::PP_BITS-1:dptw_pkg::PP_BITS];
            end
            dptw_pkg::REG_INV_DEPTH_SCALE: inv_scale = value[dptw_pkg::RECIP_BITS-1:0];
            dptw_pkg::REG_ROTATION_ROW0:   rot_row[0] = value[3*dptw_pkg::COEF_BITS-1:0];
            dptw_pkg::REG_ROTATION_ROW1:   rot_row[1] = value[3*dptw_pkg::COEF_BITS-1:0];
            dptw_pkg::REG_ROTATION_ROW2:   rot_row[2] = value[3*dptw_pkg::COEF_BITS-1:0];
            dptw_pkg::REG_TRANSLATION:     shift = value[3*dptw_pkg::TRANS_BITS-1:0];
            default: ;
         endcase
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      function int pending();
         return expected_points.size();
      endfunction

      // Back-projects one accepted pixel; a zero depth owes no point.
      function void note_pixel(pixel_type p);
         longint          z, xn, yn, acc, w;
         longint          cam [3];
         logic [dptw_pkg::COORD_BITS-1:0] coord [3];
         world_point_type pt;
         int              i, k;
         if (p.depth == '0) return;
         z  = (longint'(p.depth) * longint'(inv_scale)) >>> dptw_pkg::DEPTH_SHIFT;
         xn = ((longint'({p.column, 4'b0000}) - longint'(cx)) * longint'(inv_fx))
              >>> dptw_pkg::FOCAL_SHIFT;
         yn = ((longint'({p.row_index, 4'b0000}) - longint'(cy)) * longint'(inv_fy))
              >>> dptw_pkg::FOCAL_SHIFT;
         cam[0] = clip((xn * z) >>> dptw_pkg::CAM_SHIFT, CAM_LO, CAM_HI);
         cam[1] = clip((yn * z) >>> dptw_pkg::CAM_SHIFT, CAM_LO, CAM_HI);
         cam[2] = z;
         for (i = 0; i < 3; i++) begin
            acc = 0;
            for (k = 0; k < 3; k++)
               acc += longint'($signed(rot_row[i][k*dptw_pkg::COEF_BITS +: dptw_pkg::COEF_BITS]))
                      * cam[k];
            w = (acc >>> dptw_pkg::ROT_SHIFT)
                + longint'($signed(shift[i*dptw_pkg::TRANS_BITS +: dptw_pkg::TRANS_BITS]));
            w = clip(w, OUT_LO, OUT_HI);
            coord[i] = w[dptw_pkg::COORD_BITS-1:0];
         end
         pt.x     = coord[0];
         pt.y     = coord[1];
         pt.z     = coord[2];
         pt.blue  = p.blue;
         pt.green = p.green;
         pt.red   = p.red;
         expected_points = {expected_points, pt};
      endfunction

      task report(string msg);
         errors++;
         $display("ERROR at %0t: %s", $time, msg);
      endtask

      task compare_field(string name, longint got, longint want);
         if (got != want) report($sformatf("%s got %h want %h", name, got, want));
      endtask

      task check_point(logic [dptw_pkg::OUT_DATA_BITS-1:0] beat);
         world_point_type got, want;
         got.x     = beat[0 +: dptw_pkg::COORD_BITS];
         got.y     = beat[dptw_pkg::COORD_BITS +: dptw_pkg::COORD_BITS];
         got.z     = beat[2*dptw_pkg::COORD_BITS +: dptw_pkg::COORD_BITS];
         got.blue  = beat[3*dptw_pkg::COORD_BITS +: dptw_pkg::COLOR_BITS];
         got.green = beat[3*dptw_pkg::COORD_BITS+dptw_pkg::COLOR_BITS +: dptw_pkg::COLOR_BITS];
         got.red   = beat[3*dptw_pkg::COORD_BITS+2*dptw_pkg::COLOR_BITS +: dptw_pkg::COLOR_BITS];
         if (expected_points.size() == 0) begin
            report($sformatf("point beat %h with none expected", beat));
            return;
         end
         want = expected_points.pop_front();
         compare_field("world_x", longint'(got.x), longint'(want.x));
         compare_field("world_y", longint'(got.y), longint'(want.y));
         compare_field("world_z", longint'(got.z), longint'(want.z));
         compare_field("out_blue", longint'(got.blue), longint'(want.blue));
         compare_field("out_green", longint'(got.green), longint'(want.green));
         compare_field("out_red", longint'(got.red), longint'(want.red));
      endtask
   endclass

   logic                                   clock = 1'b0;
   logic                                   reset;
   logic                                   req_tvalid;
   logic                                   req_tready;
   logic [dptw_pkg::IN_DATA_BITS-1:0]      req_tdata;
   logic                                   rsp_tvalid;
   logic                                   rsp_tready;
   logic [dptw_pkg::OUT_DATA_BITS-1:0]     rsp_tdata;
   logic                                   csr_psel;
   logic                                   csr_penable;
   logic                                   csr_pwrite;
   logic [dptw_pkg::CSR_ADDR_BITS-1:0]     csr_paddr;
   logic [dptw_pkg::CSR_DATA_BITS-1:0]     csr_pwdata;
   logic [dptw_pkg::CSR_DATA_BITS-1:0]     csr_prdata;
   logic                                   csr_pready;

   point_scoreboard_type board = new();
   bit  source_idling = 1'b1;
   bit  sink_idling   = 1'b1;
   int  hold_count    = 0;
   int  quiet_cycles  = 0;

   depth_pixel_to_world_point dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Result side: random stalls in bursts, plus one long hold on request.
   initial begin : point_sink
      int stall_left;
      int holds_taken;
      stall_left  = 0;
      holds_taken = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_taken != hold_count) begin
            holds_taken = hold_count;
            stall_left  = LONG_HOLD;
         end else if (stall_left == 0 && sink_idling && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 19);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_point(rsp_tdata);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic pixel_type make_pixel(int col, int row, int depth, int b, int g, int r);
      pixel_type p;
      p.column    = dptw_pkg::COLUMN_BITS'(col);
      p.row_index = dptw_pkg::ROW_BITS'(row);
      p.depth     = dptw_pkg::DEPTH_BITS'(depth);
      p.blue      = dptw_pkg::COLOR_BITS'(b);
      p.green     = dptw_pkg::COLOR_BITS'(g);
      p.red       = dptw_pkg::COLOR_BITS'(r);
      return p;
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type p;
      p.column    = dptw_pkg::COLUMN_BITS'($urandom_range(0, (1 << dptw_pkg::COLUMN_BITS) - 1));
      p.row_index = dptw_pkg::ROW_BITS'($urandom_range(0, (1 << dptw_pkg::ROW_BITS) - 1));
      case ($urandom_range(0, 9))
         0:       p.depth = '0;
         1:       p.depth = dptw_pkg::DEPTH_BITS'($urandom_range(1, 15));
         2:       p.depth = dptw_pkg::DEPTH_BITS'(16'hFFFF - $urandom_range(0, 15));
         default: p.depth = dptw_pkg::DEPTH_BITS'($urandom_range(1, 65535));
      endcase
      if ($urandom_range(0, 7) == 0) p.column = $urandom_range(0, 1) ? '1 : '0;
      if ($urandom_range(0, 7) == 0) p.row_index = $urandom_range(0, 1) ? '1 : '0;
      {p.blue, p.green, p.red} = (3*dptw_pkg::COLOR_BITS)'($urandom);
      return p;
   endfunction

   function automatic reg_image_type uniform_image(
         logic [dptw_pkg::RECIP_BITS-1:0] recip,
         logic [2*dptw_pkg::PP_BITS-1:0]  pp,
         logic [dptw_pkg::COEF_BITS-1:0]  coef,
         logic [dptw_pkg::TRANS_BITS-1:0] offset);
      reg_image_type img;
      img[dptw_pkg::REG_INV_FOCAL_X]     = dptw_pkg::CSR_DATA_BITS'(recip);
      img[dptw_pkg::REG_INV_FOCAL_Y]     = dptw_pkg::CSR_DATA_BITS'(recip);
      img[dptw_pkg::REG_PRINCIPAL_POINT] = dptw_pkg::CSR_DATA_BITS'(pp);
      img[dptw_pkg::REG_INV_DEPTH_SCALE] = dptw_pkg::CSR_DATA_BITS'(recip);
      img[dptw_pkg::REG_ROTATION_ROW0]   = dptw_pkg::CSR_DATA_BITS'({3{coef}});
      img[dptw_pkg::REG_ROTATION_ROW1]   = dptw_pkg::CSR_DATA_BITS'({3{coef}});
      img[dptw_pkg::REG_ROTATION_ROW2]   = dptw_pkg::CSR_DATA_BITS'({3{coef}});
      img[dptw_pkg::REG_TRANSLATION]     = dptw_pkg::CSR_DATA_BITS'({3{offset}});
      return img;
   endfunction

   // Mostly plausible camera settings; now and then a register gets raw noise.
   function automatic reg_image_type random_image();
      reg_image_type                      img;
      logic [dptw_pkg::COEF_BITS-1:0]     coef;
      logic [dptw_pkg::CSR_DATA_BITS-1:0] row;
      int                                 i, k;
      img[dptw_pkg::REG_INV_FOCAL_X] = dptw_pkg::CSR_DATA_BITS'($urandom_range(16000, 70000));
      img[dptw_pkg::REG_INV_FOCAL_Y] = dptw_pkg::CSR_DATA_BITS'($urandom_range(16000, 70000));
      img[dptw_pkg::REG_PRINCIPAL_POINT] =
         dptw_pkg::CSR_DATA_BITS'({16'($urandom_range(0, 16383)),
                                   16'($urandom_range(0, 16383))});
      img[dptw_pkg::REG_INV_DEPTH_SCALE] =
         dptw_pkg::CSR_DATA_BITS'($urandom_range(1000, 70000));
      for (i = 0; i < 3; i++) begin
         row = '0;
         for (k = 0; k < 3; k++) begin
            coef = dptw_pkg::COEF_BITS'($urandom_range(0, 131072) - 65536);
            row[k*dptw_pkg::COEF_BITS +: dptw_pkg::COEF_BITS] = coef;
         end
         img[int'(dptw_pkg::REG_ROTATION_ROW0) + i] = row;
      end
      img[dptw_pkg::REG_TRANSLATION] = {$urandom, $urandom};
      for (i = 0; i < 8; i++)
         if ($urandom_range(0, 3) == 0) img[i] = {$urandom, $urandom};
      return img;
   endfunction

   task send_pixel(pixel_type p);
      req_tvalid <= 1'b1;
      req_tdata  <= dptw_pkg::IN_DATA_BITS'({p.red, p.green, p.blue, p.depth,
                                             p.row_index, p.column});
      do @(posedge clock); while (!req_tready);
      board.note_pixel(p);
   endtask

   // Sends the given number of random pixels, zero depths included.
   task run_pixels(int count);
      pixel_type p;
      int        sent;
      sent = 0;
      while (sent < count) begin
         p = random_pixel();
         send_pixel(p);
         sent++;
         if (source_idling && $urandom_range(0, 5) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
      end
   endtask

   task settle();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task write_reg(dptw_pkg::reg_index_type idx, logic [dptw_pkg::CSR_DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, {dptw_pkg::CSR_INDEX_LSB{1'b0}}};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.set_reg(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task program_regs(reg_image_type img);
      int i;
      settle();
      for (i = 0; i < 8; i++) write_reg(dptw_pkg::reg_index_type'(i), img[i]);
   endtask

   initial begin : stimulus
      pixel_type corner_pixels [10];
      int        phase;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Field extremes, the principal point neighborhood and dropped pixels.
      corner_pixels[0] = make_pixel(17, 40, 0, 8'h12, 8'h34, 8'h56);
      corner_pixels[1] = make_pixel(0, 0, 1, 0, 0, 0);
      corner_pixels[2] = make_pixel(1023, 1023, 65535, 255, 255, 255);
      corner_pixels[3] = make_pixel(0, 1023, 65535, 0, 255, 0);
      corner_pixels[4] = make_pixel(1023, 0, 1, 255, 0, 255);
      corner_pixels[5] = make_pixel(325, 253, 1000, 1, 2, 3);
      corner_pixels[6] = make_pixel(1023, 1023, 0, 255, 255, 255);
      corner_pixels[7] = make_pixel(10'h2AA, 10'h155, 16'hAAAA, 8'hAA, 8'h55, 8'hAA);
      corner_pixels[8] = make_pixel(10'h155, 10'h2AA, 16'h5555, 8'h55, 8'hAA, 8'h55);
      corner_pixels[9] = make_pixel(512, 512, 32768, 8'h80, 8'h7F, 8'h01);

      // Reset settings first.
      foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
      run_pixels(70);
      hold_count++;
      run_pixels(40);
      settle();
      run_pixels(40);

      // Largest gains with coefficients at the positive limit and the principal point
      // at its maximum saturate low; the most negative coefficients saturate low too.
      program_regs(uniform_image('1, '1, 18'h1FFFF, 20'h7FFFF));
      foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
      run_pixels(60);
      program_regs(uniform_image('1, '0, 18'h20000, 20'h80000));
      run_pixels(60);
      program_regs(uniform_image('0, '0, '0, '0));
      run_pixels(60);
      program_regs(uniform_image('1, '1, '1, '1));
      run_pixels(60);

      for (phase = 0; phase < 7; phase++) begin
         program_regs(random_image());
         if (phase == 6) begin
            source_idling = 1'b0;
            sink_idling   = 1'b0;
         end
         run_pixels(135);
      end
      settle();

      if (board.errors == 0 && board.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
